// ===== rtl/core/arc_pkg.sv =====
// Package: shared constants, codes and control types of the address range classifier.
`timescale 1ns / 1ps
package arc_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int ADDR_BITS   = 20;
	localparam int TABLE_DEPTH = MAX_REGIONS + 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int POS_W       = $clog2(TABLE_DEPTH);
	localparam int CLASS_W     = 3;

	localparam logic [ADDR_BITS-1:0] ADDR_MAX   = {ADDR_BITS{1'b1}};
	localparam logic [CLASS_W-1:0]   CLASS_CODE = CLASS_W'(2);

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_OVERLAP = 2'd2,
		ST_ORDER   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_COMMIT
	} fsm_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic commit;
	} arc_cmd_t;

endpackage

// ===== rtl/core/arc_req_if.sv =====
// Interface: request channel carrying insert and lookup transactions.
`timescale 1ns / 1ps
interface arc_req_if import arc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 operation;
	logic [ADDR_BITS-1:0] range_start;
	logic [ADDR_BITS-1:0] range_end;
	logic [CLASS_W-1:0]   class_code;

	modport source (output valid, output operation, output range_start, output range_end,
		output class_code, input ready);
	modport sink (input valid, input operation, input range_start, input range_end,
		input class_code, output ready);
endinterface

// ===== rtl/core/arc_rsp_if.sv =====
// Interface: response channel carrying the class and status of each transaction.
`timescale 1ns / 1ps
interface arc_rsp_if import arc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] found_class;
	logic [1:0]         status;

	modport source (output valid, output found_class, output status, input ready);
	modport sink (input valid, input found_class, input status, output ready);
endinterface

// ===== rtl/core/arc_ctrl.sv =====
// Controller: sequences accept, evaluate and commit of one transaction at a time.
`timescale 1ns / 1ps
module arc_ctrl import arc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output arc_cmd_t cmd
);

	fsm_t state_q, state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.eval   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_COMMIT;
			end
			S_COMMIT: begin
				// hold until the output register is free
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/arc_dp.sv =====
// Datapath: region table cells, parallel range compares and the result register.
`timescale 1ns / 1ps
module arc_dp import arc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  arc_cmd_t             cmd,
	input  logic                 operation,
	input  logic [ADDR_BITS-1:0] range_start,
	input  logic [ADDR_BITS-1:0] range_end,
	input  logic [CLASS_W-1:0]   class_code,
	output logic [CLASS_W-1:0]   found_class,
	output status_t              status
);

	// captured transaction
	op_t                  op_q;
	logic [ADDR_BITS-1:0] lo_q;
	logic [ADDR_BITS-1:0] hi_q;
	logic [CLASS_W-1:0]   cls_q;

	// region table, kept sorted by start; entries below count_q are live
	logic [ADDR_BITS-1:0] start_q [TABLE_DEPTH];
	logic [ADDR_BITS-1:0] end_q   [TABLE_DEPTH];
	logic [CLASS_W-1:0]   class_q [TABLE_DEPTH];
	logic [CNT_W-1:0]     count_q;

	// evaluation results
	logic [POS_W-1:0]   pos_q;
	status_t            st_q;
	logic [CLASS_W-1:0] fcls_q;

	// result register
	logic [CLASS_W-1:0] found_class_q;
	status_t            status_q;

	logic [TABLE_DEPTH-1:0] live;
	logic [TABLE_DEPTH-1:0] above;
	logic [TABLE_DEPTH-1:0] hit;
	logic [TABLE_DEPTH-1:0] clash_next;
	logic [POS_W-1:0]       pos_d;
	logic [CLASS_W-1:0]     hit_class;
	status_t                st_d;
	logic [CLASS_W-1:0]     fcls_d;

	always_comb begin
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			live[k]       = CNT_W'(k) < count_q;
			above[k]      = live[k] && (lo_q < start_q[k]);
			hit[k]        = live[k] && (start_q[k] <= lo_q) && (lo_q <= end_q[k]);
			clash_next[k] = above[k] && (start_q[k] <= hi_q);
		end
	end

	// first entry above the new start, else append; first hit for a lookup
	always_comb begin
		pos_d     = count_q[POS_W-1:0];
		hit_class = CLASS_CODE;
		for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
			if (above[k]) begin
				pos_d = POS_W'(k);
			end
			if (hit[k]) begin
				hit_class = class_q[k];
			end
		end
	end

	// table is sorted and disjoint, so only the neighbors can clash
	always_comb begin
		if (op_q == OP_LOOKUP) begin
			st_d   = ST_OK;
			fcls_d = hit_class;
		end else begin
			fcls_d = '0;
			priority if (lo_q > hi_q) begin
				st_d = ST_ORDER;
			end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
				st_d = ST_FULL;
			end else if ((|clash_next) || (|hit)) begin
				st_d = ST_OVERLAP;
			end else begin
				st_d = ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(operation);
			lo_q  <= range_start;
			hi_q  <= range_end;
			cls_q <= class_code;
		end
		if (cmd.eval) begin
			pos_q  <= pos_d;
			st_q   <= st_d;
			fcls_q <= fcls_d;
		end
		if (cmd.commit) begin
			found_class_q <= fcls_q;
			status_q      <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 2; k < TABLE_DEPTH; k++) begin
				start_q[k] <= '0;
				end_q[k]   <= '0;
				class_q[k] <= '0;
			end
			start_q[0] <= '0;
			end_q[0]   <= ADDR_BITS'(1);
			class_q[0] <= CLASS_CODE;
			start_q[1] <= ADDR_MAX;
			end_q[1]   <= ADDR_MAX;
			class_q[1] <= CLASS_CODE;
			count_q    <= CNT_W'(2);
		end else if (cmd.commit && (op_q == OP_INSERT) && (st_q == ST_OK)) begin
			// open a slot at pos_q and shift later entries up by one
			if (pos_q == '0) begin
				start_q[0] <= lo_q;
				end_q[0]   <= hi_q;
				class_q[0] <= cls_q;
			end
			for (int k = 1; k < TABLE_DEPTH; k++) begin
				if (POS_W'(k) == pos_q) begin
					start_q[k] <= lo_q;
					end_q[k]   <= hi_q;
					class_q[k] <= cls_q;
				end else if (POS_W'(k) > pos_q) begin
					start_q[k] <= start_q[k-1];
					end_q[k]   <= end_q[k-1];
					class_q[k] <= class_q[k-1];
				end
			end
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign found_class = found_class_q;
	assign status      = status_q;

endmodule

// ===== rtl/core/address_range_classifier.sv =====
// Top level: address range classifier with request and response channels.
`timescale 1ns / 1ps
// The block keeps a table of up to MAX_REGIONS + 1 disjoint address ranges,
// each tagged with a memory class and kept sorted by start address; after
// reset it holds two code ranges, 0..1 and the top address alone. An insert
// transaction places a new range at its sorted place and shifts later ranges
// up, or is refused with a status (start above end, then table full, then
// overlap with a neighbor) leaving the table as it was; its class field reads
// 0. A lookup transaction returns the class of the range holding the address,
// or code when none holds it, with status ok. Every transaction gives exactly
// one response, in order. A transaction passes accept, evaluate and commit in
// turn: the input register takes it, every table cell then compares the
// address against its range at once, and the commit loads the response
// register and shifts the table cells on an accepted insert. The next request
// is taken in the cycle after the commit, so a new transaction is not taken
// before the last one commits; a response left waiting stalls only the commit
// of the following transaction, not its acceptance.
module address_range_classifier import arc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	arc_req_if.sink   req,
	arc_rsp_if.source rsp
);

	arc_cmd_t cmd;
	status_t  status;

	// sequence: accept, evaluate, commit
	arc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// table cells, compares and response register
	arc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (req.operation),
		.range_start (req.range_start),
		.range_end   (req.range_end),
		.class_code  (req.class_code),
		.found_class (rsp.found_class),
		.status      (status)
	);

	assign rsp.status = status;

endmodule
